FILE: src/salc_pkg.sv
// Shared types and constants for the set-associative LRU tag store.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package salc_pkg;

    localparam int COUNT_W    = 32;
    localparam int ADDR_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Access kinds carried by an input word.
    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_MODIFY = 2'd1;
    localparam logic [1:0] KIND_FETCH  = 2'd2;

    // Outcome codes of one access.
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
    } item_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] eviction_total;
        logic               last_of_run;
    } result_t;

    // One way of a set as held in the line memory.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] stamp;
    } line_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd;
        logic cmp;
        logic update;
        logic second;
    } salc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic access_req;
        logic modify;
        logic clear_last;
    } salc_status_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

FILE: src/salc_ctrl.sv
// Tag store sequencer: clear, read, compare, update, modify's second access.
// Depends on salc_pkg for the command and status structs.
`timescale 1ns / 1ps

module salc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  salc_pkg::salc_status_t status,
    output salc_pkg::salc_cmd_t    cmd,
    output logic                  busy
);
    import salc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_CMP,
        ST_UPD,
        ST_SEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (start && status.access_req) state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_CMP;
            ST_CMP:   state_next = ST_UPD;
            ST_UPD:   state_next = status.modify ? ST_SEC : ST_IDLE;
            ST_SEC:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.clr_wr = (state_reg == ST_CLEAR);
        cmd.load   = (state_reg == ST_IDLE) && start;
        cmd.rd     = (state_reg == ST_ADDR);
        cmd.cmp    = (state_reg == ST_CMP);
        cmd.update = (state_reg == ST_UPD);
        cmd.second = (state_reg == ST_SEC);
    end

    assign busy = busy_reg;

endmodule

FILE: src/salc_datapath.sv
// Datapath of the LRU tag store: configuration, set memory, tag and age compare,
// replacement choice, counters and the result register. Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_datapath #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  salc_pkg::salc_cmd_t                 cmd,
    output salc_pkg::salc_status_t              status,
    input  salc_pkg::item_t                     item,
    input  logic                                cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                result_valid,
    output salc_pkg::result_t                   result
);
    import salc_pkg::*;

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    // Configuration registers.
    logic [2:0] idx_bits_reg;
    logic [3:0] ways_reg;
    logic [5:0] offset_reg;

    // Control state.
    logic [SET_W-1:0]   clr_cnt_reg;
    logic [ADDR_W-1:0]  clock_reg;
    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] misses_reg;
    logic [COUNT_W-1:0] evicts_reg;
    logic               result_valid_reg;

    // Payload registers.
    logic [1:0]                   kind_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [SET_W-1:0]             set_reg;
    logic [ADDR_W-1:0]            tag_reg;
    line_t [WAYS-1:0]             rd_row_reg;
    logic [WAYS-1:0]              hit_vec_reg;
    logic [WAYS-1:0]              free_vec_reg;
    logic [WAYS-1:0]              use_vec_reg;
    logic [WAYS-1:0][WAYS-1:0]    lt_reg;
    result_t                      result_reg;

    line_t [WAYS-1:0] mem [SETS];

    // Address split under the current geometry.
    logic [4:0]        sbits_eff;
    logic [6:0]        total_bits;
    logic [SET_W-1:0]  sel_mask;
    logic [ADDR_W-1:0] addr_shifted;
    logic [SET_W-1:0]  set_calc;
    logic [ADDR_W-1:0] tag_calc;

    always_comb
    begin
        sbits_eff    = ({2'b00, idx_bits_reg} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                                   : {2'b00, idx_bits_reg};
        total_bits   = {1'b0, offset_reg} + {2'b00, sbits_eff};
        sel_mask     = SET_W'((17'(1) << sbits_eff) - 17'(1));
        addr_shifted = addr_reg >> offset_reg;
        set_calc     = addr_shifted[SET_W-1:0] & sel_mask;
        tag_calc     = (total_bits >= 7'd64) ? '0 : (addr_reg >> total_bits[5:0]);
    end

    // Ways in use and per-way compare results.
    logic [5:0]                nways_eff;
    logic [WAYS-1:0]           use_calc;
    logic [WAYS-1:0]           hit_calc;
    logic [WAYS-1:0]           free_calc;
    logic [WAYS-1:0][WAYS-1:0] lt_calc;

    always_comb
    begin
        if (ways_reg == 4'd0)
            nways_eff = 6'd1;
        else if ({2'b00, ways_reg} > 6'(WAYS))
            nways_eff = 6'(WAYS);
        else
            nways_eff = {2'b00, ways_reg};
        for (int w = 0; w < WAYS; w++)
        begin
            use_calc[w]  = (6'(w) < nways_eff);
            hit_calc[w]  = use_calc[w] && rd_row_reg[w].valid && (rd_row_reg[w].tag == tag_reg);
            free_calc[w] = use_calc[w] && !rd_row_reg[w].valid;
            for (int j = 0; j < WAYS; j++)
                lt_calc[w][j] = (rd_row_reg[w].stamp < rd_row_reg[j].stamp);
        end
    end

    // Way choice: first hit, else first empty way, else the oldest (lowest way on ties).
    logic [WAYS-1:0]    hit_oh;
    logic [WAYS-1:0]    free_oh;
    logic [WAYS-1:0]    victim_oh;
    logic [WAYS-1:0]    sel_oh;
    logic               hit_any;
    logic               free_any;
    logic [1:0]         outcome_upd;
    logic [ADDR_W-1:0]  stamp_new;
    line_t [WAYS-1:0]   new_row;
    logic [COUNT_W-1:0] hits_upd;
    logic [COUNT_W-1:0] misses_upd;
    logic [COUNT_W-1:0] evicts_upd;

    always_comb
    begin
        hit_any  = |hit_vec_reg;
        free_any = |free_vec_reg;
        hit_oh   = hit_vec_reg & (~hit_vec_reg + WAYS'(1));
        free_oh  = free_vec_reg & (~free_vec_reg + WAYS'(1));
        for (int i = 0; i < WAYS; i++)
        begin
            victim_oh[i] = use_vec_reg[i];
            for (int j = 0; j < WAYS; j++)
            begin
                if (j < i && use_vec_reg[j])
                    victim_oh[i] = victim_oh[i] & lt_reg[i][j];
                else if (j > i && use_vec_reg[j])
                    victim_oh[i] = victim_oh[i] & !lt_reg[j][i];
            end
        end
        if (hit_any)
        begin
            sel_oh      = hit_oh;
            outcome_upd = OUT_HIT;
        end
        else if (free_any)
        begin
            sel_oh      = free_oh;
            outcome_upd = OUT_MISS;
        end
        else
        begin
            sel_oh      = victim_oh;
            outcome_upd = OUT_EVICT;
        end
        // A modify's second access always hits the line just touched, so the
        // line takes its final stamp in this one write.
        stamp_new = clock_reg + ((kind_reg == KIND_MODIFY) ? ADDR_W'(2) : ADDR_W'(1));
        for (int w = 0; w < WAYS; w++)
        begin
            if (sel_oh[w])
            begin
                new_row[w].valid = 1'b1;
                new_row[w].tag   = tag_reg;
                new_row[w].stamp = stamp_new;
            end
            else
                new_row[w] = rd_row_reg[w];
        end
        hits_upd   = hit_any ? sat_inc(hits_reg) : hits_reg;
        misses_upd = hit_any ? misses_reg : sat_inc(misses_reg);
        evicts_upd = (!hit_any && !free_any) ? sat_inc(evicts_reg) : evicts_reg;
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_bits_reg     <= 3'd0;
            ways_reg         <= 4'd1;
            offset_reg       <= 6'd0;
            clr_cnt_reg      <= '0;
            clock_reg        <= '0;
            hits_reg         <= '0;
            misses_reg       <= '0;
            evicts_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SET_BITS:    idx_bits_reg <= cfg_data[2:0];
                    CFG_WAYS:        ways_reg     <= cfg_data[3:0];
                    CFG_OFFSET_BITS: offset_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.clr_wr)
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            if (cmd.update)
            begin
                clock_reg  <= stamp_new;
                hits_reg   <= hits_upd;
                misses_reg <= misses_upd;
                evicts_reg <= evicts_upd;
            end
            else if (cmd.second)
                hits_reg <= sat_inc(hits_reg);
            result_valid_reg <= cmd.update || cmd.second;
        end
    end

    // Payload registers and the set memory.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= item.kind;
            addr_reg <= item.address;
        end
        if (cmd.rd)
        begin
            set_reg    <= set_calc;
            tag_reg    <= tag_calc;
            rd_row_reg <= mem[set_calc];
        end
        if (cmd.clr_wr)
            mem[clr_cnt_reg] <= '0;
        else if (cmd.update)
            mem[set_reg] <= new_row;
        if (cmd.cmp)
        begin
            use_vec_reg  <= use_calc;
            hit_vec_reg  <= hit_calc;
            free_vec_reg <= free_calc;
            lt_reg       <= lt_calc;
        end
        if (cmd.update)
        begin
            result_reg.outcome        <= outcome_upd;
            result_reg.hit_total      <= hits_upd;
            result_reg.miss_total     <= misses_upd;
            result_reg.eviction_total <= evicts_upd;
            result_reg.last_of_run    <= (kind_reg != KIND_MODIFY);
        end
        else if (cmd.second)
        begin
            result_reg.outcome     <= OUT_HIT;
            result_reg.hit_total   <= sat_inc(hits_reg);
            result_reg.last_of_run <= 1'b1;
        end
    end

    always_comb
    begin
        status            = '0;
        status.access_req = (item.kind == KIND_ACCESS) || (item.kind == KIND_MODIFY);
        status.modify     = (kind_reg == KIND_MODIFY);
        status.clear_last = (clr_cnt_reg == SET_W'(SETS - 1));
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: src/set_assoc_lru_cache_tag_store_top.sv
// Top level of the set-associative tag store with true LRU replacement.
// Depends on salc_pkg, salc_ctrl and salc_datapath.
//
//   Channel  | Ports                              | Handshake
//   ---------+------------------------------------+----------------------------------
//   input    | start, busy, item                  | word taken when start && !busy
//   result   | result_valid, result               | word shown for one cycle, no stall
//   config   | cfg_we, cfg_index, cfg_data        | register written when cfg_we is high
//
// A load or store word passes through the read, compare and update states before
// its result is shown, and busy is high while it does, so a new word can be taken in
// the cycle that shows the result. A modify word adds a second-access state and
// gives one result from the update state and another from the second-access state.
// An instruction fetch word is taken and dropped without raising busy.
// This sequence comes from the read, compare and write passes over the one-port
// set memory, which holds every way of a set in one row.
// After reset the sequencer clears the valid bits of one set per cycle, with busy
// high until the last set is cleared; configuration writes are taken.
// The receiver cannot hold results off, so nothing on the result side stalls.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tag_store_top #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  salc_pkg::item_t                 item,
    output logic                            busy,
    output logic                            result_valid,
    output salc_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import salc_pkg::*;

    // Commands go from the sequencer to the datapath; status comes back.
    salc_cmd_t    cmd;
    salc_status_t status;

    salc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The datapath owns the configuration, the set memory, the counters and
    // the registered result word.
    salc_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: src/salc_checker.sv
// Port-level checks on the LRU tag store's timing and result sequence.
// Depends on salc_pkg; bound to set_assoc_lru_cache_tag_store_top below.
`timescale 1ns / 1ps

module salc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input salc_pkg::item_t                 item,
    input logic                            busy,
    input logic                            result_valid,
    input salc_pkg::result_t               result,
    input logic                            cfg_we,
    input logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [salc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import salc_pkg::*;

    // A taken load or store word yields its final result after the update state.
    a_single_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind == KIND_ACCESS)
        |-> ##4 (result_valid && result.last_of_run))
        else $error("load/store result missing or not final");

    // A taken modify word yields a first, non-final result after the update state.
    a_modify_first: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind == KIND_MODIFY)
        |-> ##4 (result_valid && !result.last_of_run))
        else $error("modify first result missing");

    // The second access of a modify always hits the line the first one touched.
    a_modify_second_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_of_run)
        |=> (result_valid && result.last_of_run && result.outcome == OUT_HIT))
        else $error("modify second result is not a final hit");

    // Every eviction is also counted as a miss.
    a_miss_covers_evict: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.miss_total >= result.eviction_total))
        else $error("eviction total exceeds miss total");

    // A fetch word is dropped without occupying the block.
    a_fetch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind[1]) |=> !busy)
        else $error("fetch word made the block busy");

endmodule

bind set_assoc_lru_cache_tag_store_top salc_checker u_salc_checker (.*);

FILE: test/set_assoc_lru_cache_tag_store_top_tb.sv
// Self-checking testbench for the set-associative LRU tag store top level.
// Depends on salc_pkg and set_assoc_lru_cache_tag_store_top; drives the block through
// directed and random access traces and checks every result word against a predictor.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tag_store_top_tb;

    import salc_pkg::*;

    localparam int MAX_SET_BITS = 6;
    localparam int WAYS         = 8;
    localparam int SET_SLOTS    = 1 << MAX_SET_BITS;
    localparam int LINE_COUNT   = SET_SLOTS * WAYS;

    // A modify word is the slowest kind and pick_gap bounds every random gap, so the
    // slowest legal run of about nine hundred words stays far below this bound,
    // even with the clearing pass after reset and the drains between phases.
    localparam int CYCLE_LIMIT  = 400000;

    // Cycles allowed after the last expected result before the block is treated
    // as idle; it outlasts the deepest access, a modify, from start to result.
    localparam int SETTLE       = 10;
    localparam int PHASE_WORDS  = 88;

    // Kind 3 has no name in the package; the block treats it like a fetch.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    item_t                 item = '0;
    logic                  busy;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned cycle_count = 0;

    // The scoreboard keeps its own copy of the tag store: valid bits, tags and
    // LRU stamps for every way of every set, the access clock, the three running
    // totals and the geometry registers. Each accepted word is run through it at
    // the edge where the block takes it, and the result words it would give are
    // queued in order. Every result word the block shows is checked against the
    // head of that queue.
    class tag_store_scoreboard;
        bit          line_valid [LINE_COUNT];
        logic [63:0] line_tag   [LINE_COUNT];
        logic [63:0] line_stamp [LINE_COUNT];
        logic [63:0] access_clock;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
        logic [2:0]  idx_bits;
        logic [3:0]  ways;
        logic [5:0]  offset_bits;
        result_t     pending[$];
        int          errors;

        function new();
            for (int e = 0; e < LINE_COUNT; e++)
            begin
                line_valid[e] = 1'b0;
                line_tag[e]   = '0;
                line_stamp[e] = '0;
            end
            access_clock = '0;
            hits         = '0;
            misses       = '0;
            evictions    = '0;
            idx_bits     = 3'd0;
            ways         = 4'd1;
            offset_bits  = 6'd0;
            errors       = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_SET_BITS:    idx_bits    = data[2:0];
                CFG_WAYS:        ways        = data[3:0];
                CFG_OFFSET_BITS: offset_bits = data[5:0];
                default:         ;
            endcase
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == COUNT_MAX) ? v : v + 32'd1;
        endfunction

        // One lookup under the current geometry; returns the outcome code.
        function logic [1:0] lookup(logic [63:0] address);
            int          sbits;
            int          nways;
            int          span;
            int          base;
            int          victim;
            logic [63:0] sel_mask;
            logic [63:0] tag;
            logic [63:0] oldest;
            sbits    = (idx_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(idx_bits);
            nways    = (ways == 0) ? 1 : ((ways > WAYS) ? WAYS : int'(ways));
            span     = int'(offset_bits) + sbits;
            sel_mask = (64'd1 << sbits) - 64'd1;
            base     = int'((address >> offset_bits) & sel_mask) * WAYS;
            tag      = (span >= 64) ? 64'd0 : (address >> span);
            victim   = 0;
            oldest   = '0;
            access_clock = access_clock + 64'd1;

            for (int w = 0; w < nways; w++)
            begin
                if (line_valid[base + w] && line_tag[base + w] == tag)
                begin
                    line_stamp[base + w] = access_clock;
                    hits = bump(hits);
                    return OUT_HIT;
                end
            end

            // Fill the first empty way; failing that, the oldest stamp loses, and
            // on equal stamps the lowest way loses since the compare is strict.
            for (int w = 0; w < nways; w++)
            begin
                if (!line_valid[base + w])
                begin
                    line_valid[base + w] = 1'b1;
                    line_tag[base + w]   = tag;
                    line_stamp[base + w] = access_clock;
                    misses = bump(misses);
                    return OUT_MISS;
                end
                if (w == 0 || line_stamp[base + w] < oldest)
                begin
                    oldest = line_stamp[base + w];
                    victim = w;
                end
            end

            line_tag[base + victim]   = tag;
            line_stamp[base + victim] = access_clock;
            misses    = bump(misses);
            evictions = bump(evictions);
            return OUT_EVICT;
        endfunction

        function void queue_result(logic [1:0] outcome, logic last);
            result_t r;
            r.outcome        = outcome;
            r.hit_total      = hits;
            r.miss_total     = misses;
            r.eviction_total = evictions;
            r.last_of_run    = last;
            pending.push_back(r);
        endfunction

        function void note_word(item_t w);
            logic [1:0] outcome;
            case (w.kind)
                KIND_ACCESS:
                begin
                    outcome = lookup(w.address);
                    queue_result(outcome, 1'b1);
                end
                KIND_MODIFY:
                begin
                    outcome = lookup(w.address);
                    queue_result(outcome, 1'b0);
                    outcome = lookup(w.address);
                    queue_result(outcome, 1'b1);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        task check_word(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = pending.pop_front();
            if (got.outcome !== want.outcome)
                report_mismatch($sformatf("outcome %0d, expected %0d",
                                          got.outcome, want.outcome));
            if (got.hit_total !== want.hit_total)
                report_mismatch($sformatf("hit_total %0d, expected %0d",
                                          got.hit_total, want.hit_total));
            if (got.miss_total !== want.miss_total)
                report_mismatch($sformatf("miss_total %0d, expected %0d",
                                          got.miss_total, want.miss_total));
            if (got.eviction_total !== want.eviction_total)
                report_mismatch($sformatf("eviction_total %0d, expected %0d",
                                          got.eviction_total, want.eviction_total));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                          got.last_of_run, want.last_of_run));
        endtask
    endclass

    tag_store_scoreboard sb = new();

    set_assoc_lru_cache_tag_store_top #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // The block updates its outputs on the clock edge, so reading them at the edge
    // sees the values of the cycle that the edge closes. The receiver cannot stall,
    // so every strobed word is taken and checked.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_word(result);
    end

    // Watchdog: a block that hangs or drops results ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present a word and hold it until the block takes it. Start was raised at an
    // earlier edge, so the word goes in at the first edge that sees busy low. The
    // caller is always at a clock edge, and start is only raised here, so a word
    // following with no gap keeps start high throughout.
    task automatic send_word(logic [1:0] kind, logic [63:0] address);
        item_t w;
        w.kind    = kind;
        w.address = address;
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(w);
    endtask

    task automatic idle(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Mostly back-to-back or short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Stop sending and wait until every predicted result has been seen, then give
    // the block the SETTLE margin so that nothing is still in flight.
    task automatic wait_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges. Only called while idle.
    task automatic write_config(logic [2:0] idx_bits, logic [3:0] ways, logic [5:0] offset_bits);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SET_BITS;
        cfg_data  <= CFG_DATA_W'(idx_bits);
        @(posedge clk);
        sb.set_register(CFG_SET_BITS, CFG_DATA_W'(idx_bits));
        cfg_index <= CFG_WAYS;
        cfg_data  <= CFG_DATA_W'(ways);
        @(posedge clk);
        sb.set_register(CFG_WAYS, CFG_DATA_W'(ways));
        cfg_index <= CFG_OFFSET_BITS;
        cfg_data  <= CFG_DATA_W'(offset_bits);
        @(posedge clk);
        sb.set_register(CFG_OFFSET_BITS, CFG_DATA_W'(offset_bits));
        cfg_we <= 1'b0;
    endtask

    // One random phase under one geometry. Most addresses come from a small pool of
    // hot lines whose set field is squeezed into a few sets, so that sets fill up,
    // hit and evict in LRU order; the block offset bits of a hot line are scrambled
    // on each use, which must not change the lookup. The rest are fully random
    // addresses. Halfway through, the sender holds off until the block has drained.
    task automatic run_phase(logic [2:0] idx_bits, logic [3:0] ways, logic [5:0] offset_bits,
                             int n_words);
        logic [63:0] hot[$];
        logic [63:0] set_field;
        logic [63:0] offset_mask;
        logic [63:0] address;
        logic [1:0]  kind;
        int          sbits;
        int          pool;
        int          spread;
        int          r;
        bit          steady;
        wait_results();
        write_config(idx_bits, ways, offset_bits);
        sbits       = (idx_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(idx_bits);
        set_field   = ((64'd1 << sbits) - 64'd1) << offset_bits;
        offset_mask = (64'd1 << offset_bits) - 64'd1;
        pool        = $urandom_range(2, 24);
        spread      = $urandom_range(0, 3);
        repeat (pool)
        begin
            address = {$urandom, $urandom};
            address = (address & ~set_field)
                    | ((64'($urandom_range(0, spread)) << offset_bits) & set_field);
            hot.push_back(address);
        end
        steady = ($urandom_range(0, 3) == 0);

        for (int i = 0; i < n_words; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                kind = KIND_ACCESS;
            else if (r < 85)
                kind = KIND_MODIFY;
            else if (r < 93)
                kind = KIND_FETCH;
            else
                kind = KIND_UNUSED;
            if ($urandom_range(0, 9) == 0)
                address = {$urandom, $urandom};
            else
                address = hot[$urandom_range(0, pool - 1)] ^ ({$urandom, $urandom} & offset_mask);
            send_word(kind, address);
            if (i == n_words / 2)
                wait_results();
            else
                idle(steady ? 0 : pick_gap());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: one set, one way, no offset, so the tag is the whole
        // address. A miss, a hit, a modify that evicts and then hits, a fetch and
        // the unused kind that give nothing, and an eviction by the top address bit.
        send_word(KIND_ACCESS, 64'd0);
        send_word(KIND_ACCESS, 64'd0);
        send_word(KIND_MODIFY, '1);
        send_word(KIND_FETCH, 64'd0);
        send_word(KIND_UNUSED, '1);
        send_word(KIND_ACCESS, 64'h8000_0000_0000_0000);

        // Set bits above the maximum are clamped, a way count of zero means one, and
        // the offset plus set bits pass 64, so every tag is zero and only the top
        // address bit picks the set. Stored lines stay and are seen under this view.
        wait_results();
        write_config(3'd7, 4'd0, 6'd63);
        send_word(KIND_ACCESS, 64'd0);
        send_word(KIND_ACCESS, '1);
        send_word(KIND_ACCESS, 64'h7fff_ffff_ffff_ffff);

        // Way count above the maximum is clamped to all ways. Fill set one, refresh
        // the first tag, then force evictions that must pick the least recent line.
        wait_results();
        write_config(3'd1, 4'd12, 6'd0);
        for (int t = 1; t <= 8; t++)
            send_word(KIND_ACCESS, (64'(t) << 1) | 64'd1);
        send_word(KIND_ACCESS, 64'd3);
        send_word(KIND_MODIFY, 64'd19);
        send_word(KIND_ACCESS, 64'd5);

        // Random phases over a spread of geometries, extremes first.
        run_phase(3'd0, 4'd1, 6'd0, PHASE_WORDS);
        run_phase(3'd7, 4'd15, 6'd63, PHASE_WORDS);
        run_phase(3'd6, 4'd8, 6'd0, PHASE_WORDS);
        run_phase(3'd6, 4'd0, 6'd58, PHASE_WORDS);
        run_phase(3'd3, 4'd4, 6'd6, PHASE_WORDS);
        run_phase(3'd1, 4'd2, 6'd32, PHASE_WORDS);
        run_phase(3'd2, 4'd9, 6'd3, PHASE_WORDS);
        repeat (3)
            run_phase(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                      6'($urandom_range(0, 63)), PHASE_WORDS);

        wait_results();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
